/* rtl/core/bae_pkg.sv */
// Package for the binary arithmetic encoder: widths, codes, FSM state and
// the command/status structs shared by the controller and the datapath.
// No dependencies.
package bae_pkg;

  localparam int FREQ_W   = 14;
  localparam int CODE_W   = 31;
  localparam int PEND_W   = 16;
  localparam int FOLLOW_W = 16;
  localparam int CUM_HI_W = FREQ_W + 1;
  localparam int RANGE_W  = CODE_W + 1;
  localparam int PROD_W   = RANGE_W + CUM_HI_W;
  localparam int ITER_W   = 6;
  localparam int NUM_PADS = (CODE_W < 31) ? CODE_W : 31;
  localparam int PAD_W    = 5;

  localparam logic [CODE_W-1:0]   CODE_MASK  = {CODE_W{1'b1}};
  localparam logic [CODE_W-1:0]   CODE_MID   = CODE_W'(64'd1 << (CODE_W - 1));
  localparam logic [CODE_W-1:0]   CODE_QUART = CODE_W'(64'd1 << (CODE_W - 2));
  localparam logic [CODE_W-1:0]   CODE_3QUART = CODE_W'(64'd3 << (CODE_W - 2));
  localparam logic [CUM_HI_W-1:0] FREQ_FULL  = CUM_HI_W'(64'd1 << FREQ_W);
  localparam logic [PEND_W-1:0]   PEND_MAX   = {PEND_W{1'b1}};
  localparam logic [ITER_W-1:0]   ITER_END   = ITER_W'(CODE_W + 2);
  localparam logic [PAD_W-1:0]    PAD_LAST   = PAD_W'(NUM_PADS - 1);

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_BAD   = 2'd1,
    ST_SAT   = 2'd2,
    ST_NOBIT = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_NARROW,
    S_RENORM,
    S_CLOSE,
    S_FIN_BIT,
    S_FIN_PAD
  } state_t;

  typedef struct packed {
    logic load;
    logic mul;
    logic narrow;
    logic step;
    logic push_bad;
    logic push_close;
    logic fin_bit;
    logic fin_pad;
  } cmd_t;

  typedef struct packed {
    logic fin;
    logic bad_fields;
    logic empty;
    logic emit;
    logic stop;
    logic hold_v;
    logic out_free;
    logic pad_last;
  } sts_t;

endpackage

/* rtl/core/bae_in_if.sv */
// Input channel of the arithmetic encoder: valid/ready plus one symbol or finish item.
// Depends on bae_pkg.
interface bae_in_if;
  logic                         valid;
  logic                         ready;
  logic                         action;
  logic [bae_pkg::FREQ_W-1:0]   cum_low;
  logic [bae_pkg::CUM_HI_W-1:0] cum_high;

  modport source (output valid, action, cum_low, cum_high, input ready);
  modport sink   (input valid, action, cum_low, cum_high, output ready);
endinterface

/* rtl/core/bae_out_if.sv */
// Result channel of the arithmetic encoder: valid/ready plus one code bit transaction.
// Depends on bae_pkg.
interface bae_out_if;
  logic                         valid;
  logic                         ready;
  logic                         out_bit;
  logic [bae_pkg::FOLLOW_W-1:0] follow_count;
  logic                         is_last;
  bae_pkg::status_t             status;

  modport source (output valid, out_bit, follow_count, is_last, status, input ready);
  modport sink   (input valid, out_bit, follow_count, is_last, status, output ready);
endinterface

/* rtl/core/bae_ctrl.sv */
// Controller of the arithmetic encoder: sequences check, multiply, narrow,
// renormalize and flush. Depends on bae_pkg; drives the datapath by cmd_t.
module bae_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  bae_pkg::sts_t sts,
  output bae_pkg::cmd_t cmd
);
  import bae_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        priority if (sts.fin) begin
          state_nxt = S_FIN_BIT;
        end else if (sts.bad_fields) begin
          if (sts.out_free) begin
            cmd.push_bad = 1'b1;
            state_nxt    = S_IDLE;
          end
        end else begin
          cmd.mul   = 1'b1;
          state_nxt = S_NARROW;
        end
      end
      S_NARROW: begin
        if (sts.empty) begin
          if (sts.out_free) begin
            cmd.push_bad = 1'b1;
            state_nxt    = S_IDLE;
          end
        end else begin
          cmd.narrow = 1'b1;
          state_nxt  = S_RENORM;
        end
      end
      S_RENORM: begin
        priority if (sts.stop) begin
          state_nxt = S_CLOSE;
        end else if (!sts.emit || !sts.hold_v || sts.out_free) begin
          cmd.step = 1'b1;
        end else begin
          state_nxt = S_RENORM;
        end
      end
      S_CLOSE: begin
        if (sts.out_free) begin
          cmd.push_close = 1'b1;
          state_nxt      = S_IDLE;
        end
      end
      S_FIN_BIT: begin
        if (sts.out_free) begin
          cmd.fin_bit = 1'b1;
          state_nxt   = S_FIN_PAD;
        end
      end
      S_FIN_PAD: begin
        if (sts.out_free) begin
          cmd.fin_pad = 1'b1;
          if (sts.pad_last) begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

/* rtl/core/bae_dp.sv */
// Datapath of the arithmetic encoder: interval and pending registers, the
// range multiplier, one renormalization step per cycle unless stalled by the
// output, held result, output register. Depends on bae_pkg; commanded by bae_ctrl.
module bae_dp (
  input  logic                         clk,
  input  logic                         rst_n,
  input  bae_pkg::cmd_t                cmd,
  output bae_pkg::sts_t                sts,
  input  logic                         in_action,
  input  logic [bae_pkg::FREQ_W-1:0]   in_cum_low,
  input  logic [bae_pkg::CUM_HI_W-1:0] in_cum_high,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic                         out_bit,
  output logic [bae_pkg::FOLLOW_W-1:0] out_follow_count,
  output logic                         out_is_last,
  output bae_pkg::status_t             out_status
);
  import bae_pkg::*;

  logic [CODE_W-1:0]   low_r, low_nxt;
  logic [CODE_W-1:0]   high_r, high_nxt;
  logic [PEND_W-1:0]   pend_r, pend_nxt;
  logic                sat_r, sat_nxt;
  logic                fin_r;
  logic [FREQ_W-1:0]   cl_r;
  logic [CUM_HI_W-1:0] ch_r;
  logic [RANGE_W-1:0]  range_r;
  logic [RANGE_W-1:0]  top_r;
  logic [RANGE_W-1:0]  bot_r;
  logic [ITER_W-1:0]   iter_r;
  logic [PAD_W-1:0]    pad_r;
  logic                hold_v_r, hold_v_nxt;
  logic                hold_bit_r, hold_bit_nxt;
  logic [PEND_W-1:0]   hold_follow_r, hold_follow_nxt;
  logic                ov_r, ov_nxt;
  logic                obit_r, obit_nxt;
  logic [FOLLOW_W-1:0] ofollow_r, ofollow_nxt;
  logic                olast_r, olast_nxt;
  status_t             ostatus_r, ostatus_nxt;

  logic [PROD_W-1:0] prod_top, prod_bot;
  logic              c_lo, c_hi, c_mid, iter_end;
  logic [CODE_W-1:0] lo_sub, hi_sub;
  logic              pend_full;
  logic [PEND_W-1:0] pend_inc;

  assign prod_top  = PROD_W'(range_r) * PROD_W'(ch_r);
  assign prod_bot  = PROD_W'(range_r) * PROD_W'(cl_r);
  assign c_lo      = high_r < CODE_MID;
  assign c_hi      = low_r >= CODE_MID;
  assign c_mid     = (low_r >= CODE_QUART) && (high_r < CODE_3QUART);
  assign iter_end  = iter_r == ITER_END;
  assign pend_full = pend_r == PEND_MAX;
  assign pend_inc  = pend_full ? PEND_MAX : pend_r + PEND_W'(1);

  always_comb begin
    priority if (c_lo) begin
      lo_sub = low_r;
      hi_sub = high_r;
    end else if (c_hi) begin
      lo_sub = low_r - CODE_MID;
      hi_sub = high_r - CODE_MID;
    end else begin
      lo_sub = low_r - CODE_QUART;
      hi_sub = high_r - CODE_QUART;
    end
  end

  always_comb begin
    sts            = '0;
    sts.fin        = fin_r;
    sts.bad_fields = ({1'b0, cl_r} >= ch_r) || (ch_r > FREQ_FULL);
    sts.empty      = top_r <= bot_r;
    sts.emit       = !iter_end && (c_lo || c_hi);
    sts.stop       = iter_end || !(c_lo || c_hi || c_mid);
    sts.hold_v     = hold_v_r;
    sts.out_free   = !ov_r || out_ready;
    sts.pad_last   = pad_r == PAD_LAST;
  end

  always_comb begin
    low_nxt         = low_r;
    high_nxt        = high_r;
    pend_nxt        = pend_r;
    sat_nxt         = sat_r;
    hold_v_nxt      = hold_v_r;
    hold_bit_nxt    = hold_bit_r;
    hold_follow_nxt = hold_follow_r;
    ov_nxt          = ov_r && !out_ready;
    obit_nxt        = obit_r;
    ofollow_nxt     = ofollow_r;
    olast_nxt       = olast_r;
    ostatus_nxt     = ostatus_r;

    if (cmd.load) begin
      sat_nxt    = 1'b0;
      hold_v_nxt = 1'b0;
    end

    if (cmd.narrow) begin
      high_nxt = CODE_W'({1'b0, low_r} + top_r - RANGE_W'(1));
      low_nxt  = CODE_W'({1'b0, low_r} + bot_r);
    end

    if (cmd.step) begin
      low_nxt  = {lo_sub[CODE_W-2:0], 1'b0};
      high_nxt = {hi_sub[CODE_W-2:0], 1'b1};
      if (c_lo || c_hi) begin
        hold_v_nxt      = 1'b1;
        hold_bit_nxt    = c_hi && !c_lo;
        hold_follow_nxt = pend_r;
        pend_nxt        = '0;
        if (hold_v_r) begin
          ov_nxt      = 1'b1;
          obit_nxt    = hold_bit_r;
          ofollow_nxt = FOLLOW_W'(hold_follow_r);
          olast_nxt   = 1'b0;
          ostatus_nxt = sat_r ? ST_SAT : ST_OK;
        end
      end else begin
        pend_nxt = pend_inc;
        if (pend_full) begin
          sat_nxt = 1'b1;
        end
      end
    end

    if (cmd.push_bad) begin
      ov_nxt      = 1'b1;
      obit_nxt    = 1'b0;
      ofollow_nxt = '0;
      olast_nxt   = 1'b1;
      ostatus_nxt = ST_BAD;
    end

    if (cmd.push_close) begin
      ov_nxt     = 1'b1;
      olast_nxt  = 1'b1;
      hold_v_nxt = 1'b0;
      if (hold_v_r) begin
        obit_nxt    = hold_bit_r;
        ofollow_nxt = FOLLOW_W'(hold_follow_r);
        ostatus_nxt = sat_r ? ST_SAT : ST_OK;
      end else begin
        obit_nxt    = 1'b0;
        ofollow_nxt = '0;
        ostatus_nxt = sat_r ? ST_SAT : ST_NOBIT;
      end
    end

    if (cmd.fin_bit) begin
      ov_nxt      = 1'b1;
      obit_nxt    = low_r >= CODE_QUART;
      ofollow_nxt = FOLLOW_W'(pend_inc);
      olast_nxt   = 1'b0;
      ostatus_nxt = pend_full ? ST_SAT : ST_OK;
      sat_nxt     = pend_full;
      low_nxt     = '0;
      high_nxt    = CODE_MASK;
      pend_nxt    = '0;
    end

    if (cmd.fin_pad) begin
      ov_nxt      = 1'b1;
      obit_nxt    = 1'b0;
      ofollow_nxt = '0;
      olast_nxt   = sts.pad_last;
      ostatus_nxt = sat_r ? ST_SAT : ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      low_r    <= '0;
      high_r   <= CODE_MASK;
      pend_r   <= '0;
      sat_r    <= 1'b0;
      hold_v_r <= 1'b0;
      ov_r     <= 1'b0;
    end else begin
      low_r    <= low_nxt;
      high_r   <= high_nxt;
      pend_r   <= pend_nxt;
      sat_r    <= sat_nxt;
      hold_v_r <= hold_v_nxt;
      ov_r     <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    hold_bit_r    <= hold_bit_nxt;
    hold_follow_r <= hold_follow_nxt;
    obit_r        <= obit_nxt;
    ofollow_r     <= ofollow_nxt;
    olast_r       <= olast_nxt;
    ostatus_r     <= ostatus_nxt;
    if (cmd.load) begin
      fin_r   <= in_action;
      cl_r    <= in_cum_low;
      ch_r    <= in_cum_high;
      range_r <= RANGE_W'({1'b0, high_r} - {1'b0, low_r} + RANGE_W'(1));
      iter_r  <= '0;
      pad_r   <= '0;
    end
    if (cmd.mul) begin
      top_r <= RANGE_W'(prod_top >> FREQ_W);
      bot_r <= RANGE_W'(prod_bot >> FREQ_W);
    end
    if (cmd.step) begin
      iter_r <= iter_r + ITER_W'(1);
    end
    if (cmd.fin_pad) begin
      pad_r <= pad_r + PAD_W'(1);
    end
  end

  assign out_valid        = ov_r;
  assign out_bit          = obit_r;
  assign out_follow_count = ofollow_r;
  assign out_is_last      = olast_r;
  assign out_status       = ostatus_r;

endmodule

/* rtl/core/binary_arithmetic_encoder.sv */
// Channel    Dir  Handshake     Payload
// in_ch      in   valid/ready   action, cum_low, cum_high
// out_ch     out  valid/ready   out_bit, follow_count, is_last, status
//
// Encode: latch, multiply and narrow, then renormalization shifts at one per cycle
// while the output is not stalled (up to 33, set by the step loop), then detect
// the end of the shifts and close.
// Finish: 32 result transactions, one per cycle while the output accepts them.
// Reset (rst_n low, synchronous) returns the interval to full and pending to zero.
// A stalled output holds its result; the next input is taken while it waits.
// Top level of the arithmetic encoder; depends on bae_pkg, bae_in_if, bae_out_if,
// bae_ctrl and bae_dp.
module binary_arithmetic_encoder (
  input  logic        clk,
  input  logic        rst_n,
  bae_in_if.sink      in_ch,
  bae_out_if.source   out_ch
);
  import bae_pkg::*;

  cmd_t cmd;
  sts_t sts;

  bae_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  bae_dp u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .sts              (sts),
    .in_action        (in_ch.action),
    .in_cum_low       (in_ch.cum_low),
    .in_cum_high      (in_ch.cum_high),
    .out_valid        (out_ch.valid),
    .out_ready        (out_ch.ready),
    .out_bit          (out_ch.out_bit),
    .out_follow_count (out_ch.follow_count),
    .out_is_last      (out_ch.is_last),
    .out_status       (out_ch.status)
  );

endmodule
